// ===== hdl/i2c_slave_frame_engine_defines.svh =====
// shared assertion macros for the frame engine checkers
`ifndef I2C_SLAVE_FRAME_ENGINE_DEFINES_SVH
`define I2C_SLAVE_FRAME_ENGINE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define ISFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define ISFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/isfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isfe_pkg;

	typedef enum logic [1:0] {
		OP_ADDR = 2'd0,
		OP_READ = 2'd1,
		OP_DATA = 2'd2,
		OP_LOAD = 2'd3
	} opcode_t;

	// table selector codes
	localparam logic [1:0] SEL_PARAM  = 2'd0;
	localparam logic [1:0] SEL_ERROR  = 2'd1;
	localparam logic [1:0] SEL_STATUS = 2'd2;

	// command event codes
	localparam logic [1:0] EVT_NONE   = 2'd0;
	localparam logic [1:0] EVT_PARAM  = 2'd1;
	localparam logic [1:0] EVT_ERROR  = 2'd2;
	localparam logic [1:0] EVT_STATUS = 2'd3;

	// frame bytes
	localparam logic [7:0] SYNC0       = 8'hAA;
	localparam logic [7:0] SYNC1       = 8'h55;
	localparam logic [7:0] CMD_PAYLOAD = 8'h50;
	localparam logic [7:0] CMD_PARAM   = 8'hA0;
	localparam logic [7:0] CMD_ERROR   = 8'hA1;
	localparam logic [7:0] CMD_STATUS  = 8'hA5;

	// running sum of AA 55 cmd, the check value after each command byte
	localparam logic [7:0] SEED_PAYLOAD = 8'h4F;
	localparam logic [7:0] SEED_PARAM   = 8'h9F;
	localparam logic [7:0] SEED_ERROR   = 8'hA0;
	localparam logic [7:0] SEED_STATUS  = 8'hA4;

	localparam logic [7:0] TX_SUM_AFTER_SYNC = 8'hFF;

	typedef enum logic [2:0] {
		RX_IDLE      = 3'd0,
		RX_GOT_AA    = 3'd1,
		RX_GOT_55    = 3'd2,
		RX_PAYLOAD   = 3'd3,
		RX_CHK_PARAM = 3'd4,
		RX_CHK_ERROR = 3'd5,
		RX_CHK_STAT  = 3'd6
	} rx_phase_t;

	typedef enum logic [1:0] {
		TXM_STATUS = 2'd0,
		TXM_PARAM  = 2'd1,
		TXM_ERROR  = 2'd2
	} tx_mode_t;

	typedef enum logic {
		CS_IDLE,
		CS_READ
	} ctrl_state_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  data_byte;
		logic [1:0]  table_select;
		logic [6:0]  table_index;
		logic [15:0] table_word;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_store_valid;
		logic [7:0] rx_index;
		logic [7:0] rx_value;
		logic       rx_frame_ok;
		logic [1:0] command_event;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic tx_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
		logic needs_read;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/isfe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/isfe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isfe_ctrl
	import isfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				// a sending read waits in CS_READ for the table read
				if (cmd.accept && status.needs_read) begin
					state_d = CS_READ;
				end
			end
			CS_READ: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = (state_q == CS_IDLE) && !status.out_busy;
		cmd.accept  = s_tvalid && s_tready;
		cmd.tx_step = (state_q == CS_READ);
	end

endmodule

`default_nettype wire

// ===== hdl/isfe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isfe_datapath
	import isfe_pkg::*;
#(
	parameter int PARAM_WORDS   = 125,
	parameter int ERROR_RECORDS = 16,
	parameter int STATUS_BYTES  = 23,
	parameter int PAYLOAD_BYTES = 250
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  item,
	input  wire ctrl_cmd_t cmd,
	input  wire logic      m_tready,
	output dp_status_t     status,
	output logic           m_tvalid,
	output out_item_t      result
);

	localparam int ERR_WORDS  = ERROR_RECORDS * 5;
	localparam int PARAM_LAST = 1 + 2 * PARAM_WORDS;
	localparam int ERROR_LAST = 1 + 10 * ERROR_RECORDS;
	localparam int TX_TOP_A   = (PARAM_LAST > ERROR_LAST) ? PARAM_LAST + 1 : ERROR_LAST + 1;
	localparam int TX_TOP     = (TX_TOP_A > STATUS_BYTES) ? TX_TOP_A : STATUS_BYTES;
	localparam int TXC_W      = $clog2(TX_TOP + 1);
	localparam int RXC_W      = $clog2(PAYLOAD_BYTES + 1);
	localparam int PA_W       = (PARAM_WORDS > 1) ? $clog2(PARAM_WORDS) : 1;
	localparam int EA_W       = (ERR_WORDS > 1) ? $clog2(ERR_WORDS) : 1;
	localparam int SA_W       = (STATUS_BYTES > 1) ? $clog2(STATUS_BYTES) : 1;

	rx_phase_t        rx_phase_q, rx_phase_d;
	logic [RXC_W-1:0] rx_count_q, rx_count_d;
	logic [7:0]       rx_sum_q, rx_sum_d;
	tx_mode_t         tx_mode_q, tx_mode_d;
	logic [TXC_W-1:0] tx_count_q, tx_count_d;
	logic [7:0]       tx_sum_q, tx_sum_d;
	logic             toggle_q, toggle_d;
	logic             m_tvalid_q;
	out_item_t        result_q;

	out_item_t        res;
	logic             load_res;
	logic [7:0]       rx_sum_new;
	logic [7:0]       tx_b;
	logic [15:0]      dump_word;
	logic [TXC_W-1:0] dump_last;

	logic             param_we, error_we, status_we;
	logic [15:0]      param_rdata, error_rdata;
	logic [7:0]       status_rdata;
	logic [PA_W-1:0]  param_raddr;
	logic [EA_W-1:0]  error_raddr;
	logic [SA_W-1:0]  status_raddr;

	// word address of a dump byte is (count - 2) / 2, odd counts take the high byte
	assign param_raddr  = PA_W'((tx_count_q >> 1) - TXC_W'(1));
	assign error_raddr  = EA_W'((tx_count_q >> 1) - TXC_W'(1));
	assign status_raddr = SA_W'(tx_count_q);

	isfe_ram #(.WIDTH(16), .DEPTH(PARAM_WORDS)) u_param_ram (
		.clk   (clk),
		.we    (param_we),
		.waddr (PA_W'(item.table_index)),
		.wdata (item.table_word),
		.raddr (param_raddr),
		.rdata (param_rdata)
	);

	isfe_ram #(.WIDTH(16), .DEPTH(ERR_WORDS)) u_error_ram (
		.clk   (clk),
		.we    (error_we),
		.waddr (EA_W'(item.table_index)),
		.wdata (item.table_word),
		.raddr (error_raddr),
		.rdata (error_rdata)
	);

	isfe_ram #(.WIDTH(8), .DEPTH(STATUS_BYTES)) u_status_ram (
		.clk   (clk),
		.we    (status_we),
		.waddr (SA_W'(item.table_index)),
		.wdata (item.table_word[7:0]),
		.raddr (status_raddr),
		.rdata (status_rdata)
	);

	assign status.needs_read = (item.opcode == OP_READ) && !toggle_q;
	assign status.out_busy   = m_tvalid_q && !m_tready;

	always_comb begin
		rx_phase_d = rx_phase_q;
		rx_count_d = rx_count_q;
		rx_sum_d   = rx_sum_q;
		tx_mode_d  = tx_mode_q;
		tx_count_d = tx_count_q;
		tx_sum_d   = tx_sum_q;
		toggle_d   = toggle_q;
		res        = '0;
		load_res   = 1'b0;
		param_we   = 1'b0;
		error_we   = 1'b0;
		status_we  = 1'b0;
		rx_sum_new = rx_sum_q + item.data_byte;
		tx_b       = '0;
		dump_word  = (tx_mode_q == TXM_PARAM) ? param_rdata : error_rdata;
		dump_last  = (tx_mode_q == TXM_PARAM) ? TXC_W'(PARAM_LAST) : TXC_W'(ERROR_LAST);

		if (cmd.accept) begin
			load_res = 1'b1;
			unique case (item.opcode)
				OP_ADDR: begin
				end
				OP_READ: begin
					toggle_d = !toggle_q;
					// the byte goes out after the table read
					if (!toggle_q) begin
						load_res = 1'b0;
					end
				end
				OP_DATA: begin
					unique case (rx_phase_q)
						RX_IDLE: begin
							rx_phase_d = (item.data_byte == SYNC0) ? RX_GOT_AA : RX_IDLE;
						end
						RX_GOT_AA: begin
							if (item.data_byte == SYNC1) begin
								rx_phase_d = RX_GOT_55;
								rx_count_d = '0;
							end else begin
								rx_phase_d = RX_IDLE;
							end
						end
						RX_GOT_55: begin
							unique case (item.data_byte)
								CMD_PAYLOAD: begin
									rx_phase_d = RX_PAYLOAD;
									rx_count_d = '0;
									rx_sum_d   = SEED_PAYLOAD;
								end
								CMD_PARAM: begin
									rx_phase_d = RX_CHK_PARAM;
									rx_sum_d   = SEED_PARAM;
								end
								CMD_ERROR: begin
									rx_phase_d = RX_CHK_ERROR;
									rx_sum_d   = SEED_ERROR;
								end
								CMD_STATUS: begin
									rx_phase_d = RX_CHK_STAT;
									rx_sum_d   = SEED_STATUS;
								end
								default: begin
									rx_phase_d = RX_IDLE;
								end
							endcase
						end
						RX_PAYLOAD: begin
							rx_sum_d = rx_sum_new;
							if (rx_count_q >= RXC_W'(PAYLOAD_BYTES)) begin
								// checksum byte closes the frame
								rx_count_d      = '0;
								rx_phase_d      = RX_IDLE;
								res.rx_frame_ok = (rx_sum_new == 8'd0);
							end else begin
								res.rx_store_valid = 1'b1;
								res.rx_index       = 8'(rx_count_q);
								res.rx_value       = item.data_byte;
								rx_count_d         = rx_count_q + RXC_W'(1);
							end
						end
						RX_CHK_PARAM, RX_CHK_ERROR, RX_CHK_STAT: begin
							if (item.data_byte == rx_sum_q) begin
								// tx_sum is left alone on purpose
								tx_count_d = '0;
								unique case (rx_phase_q)
									RX_CHK_PARAM: begin
										tx_mode_d         = TXM_PARAM;
										res.command_event = EVT_PARAM;
									end
									RX_CHK_ERROR: begin
										tx_mode_d         = TXM_ERROR;
										res.command_event = EVT_ERROR;
									end
									default: begin
										tx_mode_d         = TXM_STATUS;
										res.command_event = EVT_STATUS;
									end
								endcase
							end
							rx_phase_d = RX_IDLE;
						end
						default: begin
							rx_phase_d = RX_IDLE;
						end
					endcase
				end
				OP_LOAD: begin
					unique case (item.table_select)
						SEL_PARAM:  param_we  = (9'(item.table_index) < 9'(PARAM_WORDS));
						SEL_ERROR:  error_we  = (9'(item.table_index) < 9'(ERR_WORDS));
						SEL_STATUS: status_we = (9'(item.table_index) < 9'(STATUS_BYTES));
						default: begin
						end
					endcase
				end
			endcase
		end

		if (cmd.tx_step) begin
			load_res     = 1'b1;
			res.tx_valid = 1'b1;
			unique case (tx_mode_q)
				TXM_PARAM, TXM_ERROR: begin
					priority if (tx_count_q == '0) begin
						tx_b       = SYNC0;
						tx_count_d = TXC_W'(1);
					end else if (tx_count_q == TXC_W'(1)) begin
						tx_b       = SYNC1;
						tx_count_d = TXC_W'(2);
						tx_sum_d   = TX_SUM_AFTER_SYNC;
					end else if (tx_count_q > dump_last) begin
						tx_b       = 8'd0 - tx_sum_q;
						tx_sum_d   = '0;
						tx_count_d = '0;
						tx_mode_d  = TXM_STATUS;
					end else begin
						tx_b       = tx_count_q[0] ? dump_word[15:8] : dump_word[7:0];
						tx_sum_d   = tx_sum_q + tx_b;
						tx_count_d = tx_count_q + TXC_W'(1);
					end
				end
				default: begin
					if (tx_count_q > TXC_W'(STATUS_BYTES - 1)) begin
						tx_b       = 8'd0 - tx_sum_q;
						tx_sum_d   = '0;
						tx_count_d = '0;
					end else begin
						tx_b       = status_rdata;
						tx_sum_d   = tx_sum_q + tx_b;
						tx_count_d = tx_count_q + TXC_W'(1);
					end
				end
			endcase
			res.tx_byte = tx_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q <= RX_IDLE;
			rx_count_q <= '0;
			rx_sum_q   <= '0;
			tx_mode_q  <= TXM_STATUS;
			tx_count_q <= '0;
			tx_sum_q   <= '0;
			toggle_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rx_phase_q <= rx_phase_d;
			rx_count_q <= rx_count_d;
			rx_sum_q   <= rx_sum_d;
			tx_mode_q  <= tx_mode_d;
			tx_count_q <= tx_count_d;
			tx_sum_q   <= tx_sum_d;
			toggle_q   <= toggle_d;
			if (load_res) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			result_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign result   = result_q;

endmodule

`default_nettype wire

// ===== hdl/i2c_slave_frame_engine.sv =====
// a read request that sends a byte shows its item after the registered table read,
// then the result register; every other item shows in the cycle after acceptance
// throughput: one item per cycle while results are taken; no item is taken during
// the table read of a sending read request, nor while a result waits to be taken
// reset: arst_n clears parser, transmit state, read toggle and output valid at once;
// the parameter, error and status tables are not cleared
`timescale 1ns / 1ps
`default_nettype none

module i2c_slave_frame_engine
	import isfe_pkg::*;
#(
	parameter int PARAM_WORDS   = 125,
	parameter int ERROR_RECORDS = 16,
	parameter int STATUS_BYTES  = 23,
	parameter int PAYLOAD_BYTES = 250
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // data_byte, table_index, table_word, zero pad
	input  wire logic [3:0]  s_tuser,  // opcode, table_select
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,  // tx_byte, rx_index, rx_value
	output logic      [4:0]  m_tuser   // tx_valid, rx_store_valid, rx_frame_ok, command_event
);

	in_item_t   item;
	out_item_t  result;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign item.opcode       = opcode_t'(s_tuser[1:0]);
	assign item.table_select = s_tuser[3:2];
	assign item.data_byte    = s_tdata[7:0];
	assign item.table_index  = s_tdata[14:8];
	assign item.table_word   = s_tdata[30:15];

	isfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	isfe_datapath #(
		.PARAM_WORDS   (PARAM_WORDS),
		.ERROR_RECORDS (ERROR_RECORDS),
		.STATUS_BYTES  (STATUS_BYTES),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.m_tready (m_tready),
		.status   (status),
		.m_tvalid (m_tvalid),
		.result   (result)
	);

	assign m_tdata = {result.rx_value, result.rx_index, result.tx_byte};
	assign m_tuser = {result.command_event, result.rx_frame_ok, result.rx_store_valid,
		result.tx_valid};

endmodule

`default_nettype wire

// ===== hdl/isfe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_slave_frame_engine_defines.svh"

module isfe_checker #(
	parameter int PAYLOAD_BYTES = 250
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [4:0]  m_tuser
);

	// a stalled item holds
	`ISFE_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled item changed")

	// an item reports at most one kind of event
	`ISFE_ASSERT_NOW(a_one_event, m_tvalid, $countones({m_tuser[2:0], m_tuser[4:3] != 2'd0}) <= 1, "more than one event in an item")

	// payload fields are zero unless a payload byte is reported, and the index stays in the frame
	`ISFE_ASSERT_NOW(a_rx_fields, m_tvalid, m_tuser[1] ? (m_tdata[15:8] < 8'(PAYLOAD_BYTES)) : (m_tdata[23:8] == 16'd0), "bad payload fields")

	// no new item is taken while a result waits
	`ISFE_ASSERT_NOW(a_no_accept_stalled, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

endmodule

bind i2c_slave_frame_engine isfe_checker #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_isfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import isfe_pkg::*;

	localparam int PARAM_WORDS   = 125;
	localparam int ERROR_RECORDS = 16;
	localparam int STATUS_BYTES  = 23;
	localparam int PAYLOAD_BYTES = 250;
	localparam int ERR_WORDS     = ERROR_RECORDS * 5;

	// selector value that no table answers to, and a command byte nobody decodes
	localparam logic [1:0] SEL_NONE    = 2'd3;
	localparam logic [7:0] CMD_UNKNOWN = 8'h77;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [4:0]  m_tuser;

	// engine state as predicted from the accepted items
	rx_phase_t   parse_phase = RX_IDLE;
	int          parse_count = 0;
	logic [7:0]  parse_sum = '0;
	tx_mode_t    dump_mode = TXM_STATUS;
	int          dump_count = 0;
	logic [7:0]  dump_sum = '0;
	logic        read_skip = 1'b0;
	logic [15:0] param_mem [PARAM_WORDS];
	logic [15:0] errlog_mem [ERR_WORDS];
	logic [7:0]  status_mem [STATUS_BYTES];

	out_item_t pending_outputs [$];
	int        items_sent = 0;
	int        results_seen = 0;
	int        mismatch_count = 0;
	int        send_idle_pct = 21;
	int        recv_idle_pct = 53;

	i2c_slave_frame_engine #(
		.PARAM_WORDS  (PARAM_WORDS),
		.ERROR_RECORDS(ERROR_RECORDS),
		.STATUS_BYTES (STATUS_BYTES),
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// next output of the engine for one accepted item, advancing the predicted state
	function automatic out_item_t engine_step(input in_item_t it);
		out_item_t   r;
		logic [7:0]  b;
		logic [15:0] w;
		int          k;
		int          last;
		r = '0;
		case (it.opcode)
			OP_READ: begin
				read_skip = ~read_skip;
				if (read_skip) begin
					r.tx_valid = 1'b1;
					last = (dump_mode == TXM_PARAM) ? 2 * PARAM_WORDS + 1 : 10 * ERROR_RECORDS + 1;
					if (dump_mode == TXM_STATUS) begin
						if (dump_count > STATUS_BYTES - 1) begin
							b = -dump_sum;
							dump_sum = '0;
							dump_count = 0;
						end else begin
							b = status_mem[dump_count];
							dump_sum += b;
							dump_count++;
						end
					end else if (dump_count == 0) begin
						b = SYNC0;
						dump_count = 1;
					end else if (dump_count == 1) begin
						b = SYNC1;
						dump_count = 2;
						dump_sum = TX_SUM_AFTER_SYNC;
					end else if (dump_count > last) begin
						b = -dump_sum;
						dump_sum = '0;
						dump_count = 0;
						dump_mode = TXM_STATUS;
					end else begin
						k = dump_count - 2;
						// each error record is 10 bytes, so byte parity matches word half
						if (dump_mode == TXM_PARAM)
							w = param_mem[k >> 1];
						else
							w = errlog_mem[(k / 10) * 5 + (k % 10) / 2];
						b = k[0] ? w[15:8] : w[7:0];
						dump_sum += b;
						dump_count++;
					end
					r.tx_byte = b;
				end
			end
			OP_DATA: begin
				case (parse_phase)
					RX_IDLE: begin
						if (it.data_byte == SYNC0)
							parse_phase = RX_GOT_AA;
					end
					RX_GOT_AA: begin
						if (it.data_byte == SYNC1) begin
							parse_phase = RX_GOT_55;
							parse_count = 0;
						end else begin
							parse_phase = RX_IDLE;
						end
					end
					RX_GOT_55: begin
						case (it.data_byte)
							CMD_PAYLOAD: begin
								parse_phase = RX_PAYLOAD;
								parse_count = 0;
								parse_sum = SEED_PAYLOAD;
							end
							CMD_PARAM: begin
								parse_phase = RX_CHK_PARAM;
								parse_sum = SEED_PARAM;
							end
							CMD_ERROR: begin
								parse_phase = RX_CHK_ERROR;
								parse_sum = SEED_ERROR;
							end
							CMD_STATUS: begin
								parse_phase = RX_CHK_STAT;
								parse_sum = SEED_STATUS;
							end
							default: parse_phase = RX_IDLE;
						endcase
					end
					RX_PAYLOAD: begin
						parse_sum += it.data_byte;
						if (parse_count > PAYLOAD_BYTES - 1) begin
							parse_count = 0;
							parse_phase = RX_IDLE;
							r.rx_frame_ok = (parse_sum == 8'h00);
						end else begin
							r.rx_store_valid = 1'b1;
							r.rx_index = 8'(parse_count);
							r.rx_value = it.data_byte;
							parse_count++;
						end
					end
					RX_CHK_PARAM, RX_CHK_ERROR, RX_CHK_STAT: begin
						if (it.data_byte == parse_sum) begin
							// tx_sum is left alone, only the count restarts
							dump_count = 0;
							if (parse_phase == RX_CHK_PARAM) begin
								dump_mode = TXM_PARAM;
								r.command_event = EVT_PARAM;
							end else if (parse_phase == RX_CHK_ERROR) begin
								dump_mode = TXM_ERROR;
								r.command_event = EVT_ERROR;
							end else begin
								dump_mode = TXM_STATUS;
								r.command_event = EVT_STATUS;
							end
						end
						parse_phase = RX_IDLE;
					end
					default: parse_phase = RX_IDLE;
				endcase
			end
			OP_LOAD: begin
				case (it.table_select)
					SEL_PARAM: begin
						if (it.table_index < PARAM_WORDS)
							param_mem[it.table_index] = it.table_word;
					end
					SEL_ERROR: begin
						if (it.table_index < ERR_WORDS)
							errlog_mem[it.table_index] = it.table_word;
					end
					SEL_STATUS: begin
						if (it.table_index < STATUS_BYTES)
							status_mem[it.table_index] = it.table_word[7:0];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : result_check
		out_item_t got;
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tx_valid       = m_tuser[0];
			got.rx_store_valid = m_tuser[1];
			got.rx_frame_ok    = m_tuser[2];
			got.command_event  = m_tuser[4:3];
			got.tx_byte        = m_tdata[7:0];
			got.rx_index       = m_tdata[15:8];
			got.rx_value       = m_tdata[23:16];
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
			end else begin
				want = pending_outputs.pop_front();
				if (got.tx_valid !== want.tx_valid)
					report_mismatch($sformatf("result %0d tx_valid %b, expected %b",
						results_seen, got.tx_valid, want.tx_valid));
				if (got.tx_byte !== want.tx_byte)
					report_mismatch($sformatf("result %0d tx_byte %h, expected %h",
						results_seen, got.tx_byte, want.tx_byte));
				if (got.rx_store_valid !== want.rx_store_valid)
					report_mismatch($sformatf("result %0d rx_store_valid %b, expected %b",
						results_seen, got.rx_store_valid, want.rx_store_valid));
				if (got.rx_index !== want.rx_index)
					report_mismatch($sformatf("result %0d rx_index %0d, expected %0d",
						results_seen, got.rx_index, want.rx_index));
				if (got.rx_value !== want.rx_value)
					report_mismatch($sformatf("result %0d rx_value %h, expected %h",
						results_seen, got.rx_value, want.rx_value));
				if (got.rx_frame_ok !== want.rx_frame_ok)
					report_mismatch($sformatf("result %0d rx_frame_ok %b, expected %b",
						results_seen, got.rx_frame_ok, want.rx_frame_ok));
				if (got.command_event !== want.command_event)
					report_mismatch($sformatf("result %0d command_event %0d, expected %0d",
						results_seen, got.command_event, want.command_event));
			end
			results_seen++;
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic in_item_t rand_item(input opcode_t op);
		in_item_t it;
		it.opcode       = op;
		it.data_byte    = 8'($urandom_range(255));
		it.table_select = 2'($urandom_range(3));
		it.table_index  = 7'($urandom_range(127));
		it.table_word   = 16'($urandom_range(65535));
		return it;
	endfunction

	// called from just after a rising clock; returns once the item has been accepted
	task automatic send_item(input in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, it.table_word, it.table_index, it.data_byte};
		s_tuser  <= {it.table_select, it.opcode};
		do @(posedge clk); while (!s_tready);
		pending_outputs.push_back(engine_step(it));
		items_sent++;
	endtask

	task automatic send_data(input logic [7:0] d);
		in_item_t it;
		it = rand_item(OP_DATA);
		it.data_byte = d;
		send_item(it);
	endtask

	task automatic send_reads(input int n);
		repeat (n) send_item(rand_item(OP_READ));
	endtask

	task automatic load_entry(input logic [1:0] sel, input int idx, input logic [15:0] word);
		in_item_t it;
		it = rand_item(OP_LOAD);
		it.table_select = sel;
		it.table_index  = 7'(idx);
		it.table_word   = word;
		send_item(it);
	endtask

	task automatic send_command(input logic [7:0] cmd, input bit good);
		logic [7:0] chk;
		chk = SYNC0 + SYNC1 + cmd;
		if (!good)
			chk = chk + 8'($urandom_range(1, 255));
		send_data(SYNC0);
		send_data(SYNC1);
		send_data(cmd);
		send_data(chk);
	endtask

	// payload frame; other kinds of items slip in between bytes now and then
	task automatic send_payload_frame(input bit good, input int noise_pct);
		logic [7:0] sum;
		logic [7:0] b;
		sum = SYNC0 + SYNC1 + CMD_PAYLOAD;
		send_data(SYNC0);
		send_data(SYNC1);
		send_data(CMD_PAYLOAD);
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (i == 0)
				b = 8'h00;
			else if (i == PAYLOAD_BYTES - 1)
				b = 8'hFF;
			else
				b = 8'($urandom_range(255));
			sum += b;
			send_data(b);
			if ($urandom_range(99) < noise_pct) begin
				case ($urandom_range(2))
					0: send_item(rand_item(OP_ADDR));
					1: send_item(rand_item(OP_READ));
					default: send_item(rand_item(OP_LOAD));
				endcase
			end
		end
		b = -sum;
		if (!good)
			b = b + 8'($urandom_range(1, 255));
		send_data(b);
	endtask

	function automatic logic [15:0] fill_word(input int i);
		if (i == 0)
			return 16'h0000;
		if (i == 1)
			return 16'hFFFF;
		return 16'($urandom_range(65535));
	endfunction

	// every entry is written before anything can read it
	task automatic test_table_fill();
		for (int i = 0; i < PARAM_WORDS; i++)
			load_entry(SEL_PARAM, i, fill_word(i));
		for (int i = 0; i < ERR_WORDS; i++)
			load_entry(SEL_ERROR, i, fill_word(i));
		for (int i = 0; i < STATUS_BYTES; i++)
			load_entry(SEL_STATUS, i, fill_word(i));
		load_entry(SEL_PARAM, PARAM_WORDS, 16'($urandom_range(65535)));
		load_entry(SEL_PARAM, 127, 16'($urandom_range(65535)));
		load_entry(SEL_ERROR, ERR_WORDS, 16'($urandom_range(65535)));
		load_entry(SEL_ERROR, 127, 16'($urandom_range(65535)));
		load_entry(SEL_STATUS, STATUS_BYTES, 16'($urandom_range(65535)));
		load_entry(SEL_STATUS, 127, 16'($urandom_range(65535)));
		load_entry(SEL_NONE, 0, 16'($urandom_range(65535)));
		load_entry(SEL_NONE, 1, 16'($urandom_range(65535)));
	endtask

	task automatic test_directed();
		send_item(rand_item(OP_ADDR));
		send_reads(2);
		// the second AA is not taken as a new sync, so the 55 lands in idle
		send_data(SYNC0);
		send_data(SYNC0);
		send_data(SYNC1);
		send_data(SYNC0);
		send_data(SYNC1);
		send_data(CMD_UNKNOWN);
		send_command(CMD_ERROR, 1'b0);
		send_command(CMD_PARAM, 1'b1);
		send_reads(4);
		// refresh in the middle of a dump restarts the count, keeps the sum
		send_command(CMD_STATUS, 1'b1);
	endtask

	task automatic test_payload_frames();
		send_payload_frame(1'b1, 10);
		send_payload_frame(1'b0, 10);
	endtask

	task automatic test_full_dumps();
		send_command(CMD_PARAM, 1'b1);
		send_reads(2 * (2 * PARAM_WORDS + 3) + 2);
		send_command(CMD_ERROR, 1'b1);
		send_reads(2 * (10 * ERROR_RECORDS + 3) + 2);
		send_command(CMD_STATUS, 1'b1);
		send_reads(2 * (STATUS_BYTES + 1) + 2);
	endtask

	task automatic test_random(input int items, input int snd_pct, input int rcv_pct);
		int         start;
		int         r;
		int         n;
		logic [7:0] cmd;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		start = items_sent;
		while (items_sent - start < items) begin
			r = $urandom_range(99);
			if (r < 40) begin
				case ($urandom_range(2))
					0: cmd = CMD_PARAM;
					1: cmd = CMD_ERROR;
					default: cmd = CMD_STATUS;
				endcase
				send_command(cmd, $urandom_range(4) != 0);
				send_reads($urandom_range(1, 60));
			end else if (r < 60) begin
				send_reads($urandom_range(1, 40));
			end else if (r < 75) begin
				// broken header: stops after AA, or carries any byte after AA or AA 55
				send_data(SYNC0);
				n = $urandom_range(2);
				if (n == 0) begin
					send_data(8'($urandom_range(255)));
				end else if (n == 1) begin
					send_data(SYNC1);
					send_data(8'($urandom_range(255)));
				end
			end else if (r < 90) begin
				repeat ($urandom_range(1, 10))
					send_item(rand_item(opcode_t'($urandom_range(3))));
			end else begin
				repeat ($urandom_range(1, 5)) begin
					case ($urandom_range(2))
						0: load_entry(SEL_PARAM, $urandom_range(PARAM_WORDS - 1),
							16'($urandom_range(65535)));
						1: load_entry(SEL_ERROR, $urandom_range(ERR_WORDS - 1),
							16'($urandom_range(65535)));
						default: load_entry(SEL_STATUS, $urandom_range(STATUS_BYTES - 1),
							16'($urandom_range(65535)));
					endcase
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_directed();
		test_payload_frames();
		test_full_dumps();
		test_random(45, 21, 53);
		test_random(45, 53, 21);
		test_random(45, 0, 0);
		s_tvalid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
